/* rtl/phs_pkg.sv */
// ----------------------------------------------------------------------------
// Partition header scorer package
// Item types, header layout constants, scoring weights and check helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package phs_pkg;

   localparam int WORD_W = 32;
   localparam int PRIOR_W = 9;
   localparam int POS_W = 9;
   localparam int SCORE_W = 7;
   localparam int KIND_W = 16;
   localparam int NAME_W = 3;

   localparam logic [WORD_W-1:0] MAGIC_WORD = 32'h0041_5041;
   localparam logic [WORD_W-1:0] MAX_SUBS = 32'd64;

   localparam logic [POS_W-1:0] POS_STORED = 9'd0;
   localparam logic [POS_W-1:0] POS_MAGIC = 9'd1;
   localparam logic [POS_W-1:0] POS_NEXT = 9'd2;
   localparam logic [POS_W-1:0] POS_PREV = 9'd3;
   localparam logic [POS_W-1:0] POS_NAME_FIRST = 9'd4;
   localparam logic [POS_W-1:0] POS_NAME_LAST = 9'd11;
   localparam logic [POS_W-1:0] POS_START = 9'd16;
   localparam logic [POS_W-1:0] POS_LENGTH = 9'd17;
   localparam logic [POS_W-1:0] POS_KIND = 9'd18;
   localparam logic [POS_W-1:0] POS_SUBS = 9'd19;
   localparam logic [POS_W-1:0] POS_MAIN = 9'd22;

   localparam logic [7:0] PRINT_LOW = 8'h20;
   localparam logic [7:0] PRINT_HIGH = 8'h7e;

   localparam int NAME_SEEN = 0;
   localparam int NAME_BAD = 1;
   localparam int NAME_ENDED = 2;

   localparam int EV_MAGIC = 0;
   localparam int EV_SELF = 1;
   localparam int EV_SUM = 2;
   localparam int EV_EXTENT = 3;
   localparam int EV_SUBS = 4;
   localparam int EV_TYPE = 5;
   localparam int EV_ID = 6;
   localparam int EV_REFERENCED = 7;

   localparam logic [SCORE_W-1:0] PTS_MAGIC = 7'd25;
   localparam logic [SCORE_W-1:0] PTS_SELF = 7'd20;
   localparam logic [SCORE_W-1:0] PTS_SUM = 7'd20;
   localparam logic [SCORE_W-1:0] PTS_EXTENT = 7'd15;
   localparam logic [SCORE_W-1:0] PTS_SUBS = 7'd5;
   localparam logic [SCORE_W-1:0] PTS_TYPE = 7'd5;
   localparam logic [SCORE_W-1:0] PTS_ID = 7'd10;
   localparam logic [SCORE_W-1:0] SCORE_MAX = 7'd100;
   localparam logic [SCORE_W-1:0] ACCEPT_MIN = 7'd30;
   localparam logic [SCORE_W-1:0] ACCEPT_MIN_ZERO = 7'd20;

   localparam logic [KIND_W-1:0] KIND_EMPTY = 16'h0000;
   localparam logic [KIND_W-1:0] KIND_ONE = 16'h0001;
   localparam logic [KIND_W-1:0] KIND_SWAP = 16'h0082;
   localparam logic [KIND_W-1:0] KIND_NATIVE = 16'h0083;
   localparam logic [KIND_W-1:0] KIND_88 = 16'h0088;
   localparam logic [KIND_W-1:0] KIND_FS = 16'h0100;
   localparam logic [KIND_W-1:0] KIND_FS_ALT = 16'h0101;
   localparam logic [KIND_W-1:0] KIND_SPECIAL = 16'h1337;

   typedef struct packed {
      logic [WORD_W-1:0] header_word;
      logic last_word;
      logic [WORD_W-1:0] sector_addr;
      logic [PRIOR_W-1:0] prior_evidence;
   } req_type;

   typedef struct packed {
      logic [SCORE_W-1:0] confidence;
      logic [PRIOR_W-1:0] evidence_bits;
      logic [WORD_W-1:0] computed_sum;
      logic [WORD_W-1:0] stored_sum;
      logic accept;
      logic [WORD_W-1:0] next_link;
      logic [WORD_W-1:0] prev_link;
      logic [WORD_W-1:0] start_sector;
      logic [WORD_W-1:0] length_sectors;
      logic [WORD_W-1:0] main_link;
      logic [WORD_W-1:0] sub_count;
      logic [KIND_W-1:0] part_type;
   } rsp_type;

   typedef struct packed {
      logic [WORD_W-1:0] sector;
      logic [PRIOR_W-1:0] prior;
      logic [WORD_W-1:0] stored;
      logic [WORD_W-1:0] sum;
      logic magic;
      logic [WORD_W-1:0] next;
      logic [WORD_W-1:0] prev;
      logic [WORD_W-1:0] start;
      logic [WORD_W-1:0] length;
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] subs;
      logic [WORD_W-1:0] main;
      logic [NAME_W-1:0] name;
   } snap_type;

   typedef struct packed {
      logic valid;
      snap_type snap;
   } snap_chan_type;

   function automatic logic type_ok(input logic [KIND_W-1:0] kind);
      logic ok;
      case (kind) inside
         KIND_EMPTY, KIND_ONE, KIND_SWAP, KIND_NATIVE,
         KIND_88, KIND_FS, KIND_FS_ALT, KIND_SPECIAL: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic logic [NAME_W-1:0] scan_name_byte(input logic [NAME_W-1:0] flags,
                                                        input logic [7:0] b);
      logic [NAME_W-1:0] res;
      res = flags;
      if (!flags[NAME_ENDED] && !flags[NAME_BAD]) begin
         if (b == 8'h00) begin
            res[NAME_ENDED] = 1'b1;
         end else if (b < PRINT_LOW || b > PRINT_HIGH) begin
            res[NAME_BAD] = 1'b1;
         end else begin
            res[NAME_SEEN] = 1'b1;
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/phs_front.sv */
// ----------------------------------------------------------------------------
// Partition header scorer front end
// Accumulates header words, captures fields and hands a snapshot per header.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module phs_front
   import phs_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic take,
   input wire req_type req,
   output snap_chan_type snap_out
);

   logic [POS_W-1:0] pos_ff, pos_in;
   snap_type held_ff, held_in;
   logic [NAME_W-1:0] name_scan;

   always_comb begin
      name_scan = held_ff.name;
      for (int k = 0; k < 4; k++) begin
         name_scan = scan_name_byte(name_scan, req.header_word[8*k +: 8]);
      end
   end

   always_comb begin
      held_in = held_ff;
      pos_in = pos_ff;
      if (pos_ff == POS_STORED) begin
         held_in = '0;
         held_in.sector = req.sector_addr;
         held_in.prior = req.prior_evidence;
         held_in.stored = req.header_word;
      end else if (!pos_ff[POS_W-1]) begin
         held_in.sum = held_ff.sum + req.header_word;
         if (pos_ff == POS_MAGIC) begin
            held_in.magic = (req.header_word == MAGIC_WORD);
         end
         if (pos_ff == POS_NEXT) begin
            held_in.next = req.header_word;
         end
         if (pos_ff == POS_PREV) begin
            held_in.prev = req.header_word;
         end
         if (pos_ff == POS_START) begin
            held_in.start = req.header_word;
         end
         if (pos_ff == POS_LENGTH) begin
            held_in.length = req.header_word;
         end
         if (pos_ff == POS_KIND) begin
            held_in.kind = req.header_word[KIND_W-1:0];
         end
         if (pos_ff == POS_SUBS) begin
            held_in.subs = req.header_word;
         end
         if (pos_ff == POS_MAIN) begin
            held_in.main = req.header_word;
         end
         if (pos_ff >= POS_NAME_FIRST && pos_ff <= POS_NAME_LAST) begin
            held_in.name = name_scan;
         end
      end
      if (req.last_word) begin
         pos_in = '0;
      end else if (!pos_ff[POS_W-1]) begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         held_ff <= '0;
      end else if (take) begin
         pos_ff <= pos_in;
         held_ff <= held_in;
      end
   end

   assign snap_out.valid = take && req.last_word;
   assign snap_out.snap = held_in;

endmodule

`default_nettype wire

/* rtl/phs_queue.sv */
// ----------------------------------------------------------------------------
// Partition header scorer snapshot queue
// Two-entry queue that decouples the front end from the scoring stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module phs_queue
   import phs_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire snap_chan_type wr,
   output logic full,
   output snap_chan_type rd,
   input wire logic rd_take
);

   snap_type mem_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic do_wr, do_rd;

   assign full = (count_ff == 2'd2);
   assign do_wr = wr.valid && !full;
   assign do_rd = rd_take && (count_ff != 2'd0);

   assign rd.valid = (count_ff != 2'd0);
   assign rd.snap = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_wr;
      rd_ptr_in = rd_ptr_ff ^ do_rd;
      count_in = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr.snap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/phs_back.sv */
// ----------------------------------------------------------------------------
// Partition header scorer back end
// Runs the plausibility checks on a snapshot and holds the result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module phs_back
   import phs_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_write,
   input wire logic [WORD_W-1:0] csr_data,
   input wire snap_chan_type head,
   output logic head_take,
   output logic rsp_empty,
   input wire logic rsp_pop,
   output rsp_type rsp_data
);

   logic [WORD_W-1:0] disk_ff;
   rsp_type rsp_ff, rsp_in;
   logic valid_ff, valid_in;
   snap_type s;
   logic [PRIOR_W-1:0] ev;
   logic [SCORE_W-1:0] score;
   logic [WORD_W:0] extent_end;
   logic anchor;

   assign s = head.snap;
   assign head_take = head.valid && (!valid_ff || rsp_pop);

   always_comb begin
      ev = s.prior;
      score = '0;
      extent_end = {1'b0, s.start} + {1'b0, s.length};
      if (s.magic) begin
         ev[EV_MAGIC] = 1'b1;
         score = score + PTS_MAGIC;
      end
      if (s.start == s.sector) begin
         ev[EV_SELF] = 1'b1;
         score = score + PTS_SELF;
      end
      anchor = s.prior[EV_REFERENCED] || ev[EV_MAGIC] || ev[EV_SELF];
      rsp_in.computed_sum = '0;
      if (!anchor) begin
         score = '0;
      end else begin
         rsp_in.computed_sum = s.sum;
         if (s.stored == s.sum) begin
            ev[EV_SUM] = 1'b1;
            score = score + PTS_SUM;
         end
         if (s.length != '0 && s.start < disk_ff && extent_end <= {1'b0, disk_ff}) begin
            ev[EV_EXTENT] = 1'b1;
            score = score + PTS_EXTENT;
         end
         if (s.subs <= MAX_SUBS) begin
            ev[EV_SUBS] = 1'b1;
            score = score + PTS_SUBS;
         end
         if (type_ok(s.kind)) begin
            ev[EV_TYPE] = 1'b1;
            score = score + PTS_TYPE;
         end
         if (s.name[NAME_SEEN] && !s.name[NAME_BAD]) begin
            ev[EV_ID] = 1'b1;
            score = score + PTS_ID;
         end
         if (!ev[EV_MAGIC] && !ev[EV_EXTENT] && !ev[EV_ID]) begin
            score = '0;
         end
         if (score > SCORE_MAX) begin
            score = SCORE_MAX;
         end
      end
      rsp_in.confidence = score;
      rsp_in.evidence_bits = ev;
      rsp_in.stored_sum = s.stored;
      rsp_in.accept = (score >= ACCEPT_MIN) || (s.sector == '0 && score >= ACCEPT_MIN_ZERO);
      rsp_in.next_link = s.next;
      rsp_in.prev_link = s.prev;
      rsp_in.start_sector = s.start;
      rsp_in.length_sectors = s.length;
      rsp_in.main_link = s.main;
      rsp_in.sub_count = s.subs;
      rsp_in.part_type = s.kind;
   end

   always_comb begin
      valid_in = valid_ff;
      if (head_take) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (head_take) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         disk_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (csr_write) begin
            disk_ff <= csr_data;
         end
      end
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

/* rtl/partition_header_scorer.sv */
// ----------------------------------------------------------------------------
// Partition header scorer
// Scores a streamed partition header (first 256 words) for plausibility.
// ----------------------------------------------------------------------------
// The block takes one header word per cycle, back to back, while req_full is
// low; req_full is high while the snapshot queue is full. The item that
// carries last_word closes a header; its snapshot is written to the snapshot
// queue and, once the result side is free, scored into the result register
// that drives the rsp_ ports. The two-entry queue lets the front end keep
// taking words while a finished result waits to be popped. The disk size
// register may be written at any time through the csr_ channel, which is
// always ready, but it should only change while no header is in flight.
`timescale 1ns / 1ps
`default_nettype none

module partition_header_scorer
   import phs_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_push,
   output logic req_full,
   input wire req_type req_data,
   output logic rsp_empty,
   input wire logic rsp_pop,
   output rsp_type rsp_data,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [WORD_W-1:0] csr_data
);

   snap_chan_type front_snap;
   snap_chan_type queue_head;
   logic queue_full;
   logic head_take;
   logic take;

   assign req_full = queue_full;
   assign take = req_push && !queue_full;
   assign csr_ready = 1'b1;

   phs_front u_front (
      .clock(clock),
      .reset(reset),
      .take(take),
      .req(req_data),
      .snap_out(front_snap)
   );

   phs_queue u_queue (
      .clock(clock),
      .reset(reset),
      .wr(front_snap),
      .full(queue_full),
      .rd(queue_head),
      .rd_take(head_take)
   );

   phs_back u_back (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_valid && csr_ready),
      .csr_data(csr_data),
      .head(queue_head),
      .head_take(head_take),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data)
   );

endmodule

`default_nettype wire

/* rtl/phs_checker.sv */
// ----------------------------------------------------------------------------
// Partition header scorer checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module phs_checker
   import phs_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_empty,
   input wire logic rsp_pop,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("result item changed while waiting");

   a_score_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.confidence <= SCORE_MAX))
      else $error("confidence above maximum");

   a_accept_rule: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_data.confidence < ACCEPT_MIN || rsp_data.accept) &&
         (!rsp_data.accept || rsp_data.confidence >= ACCEPT_MIN_ZERO)))
      else $error("accept flag inconsistent with confidence");

   a_semantic_anchor: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.confidence != '0) |->
         (rsp_data.evidence_bits[EV_MAGIC] || rsp_data.evidence_bits[EV_EXTENT] ||
          rsp_data.evidence_bits[EV_ID]))
      else $error("nonzero confidence without semantic anchor");

endmodule

bind partition_header_scorer phs_checker u_phs_checker (
   .clock(clock),
   .reset(reset),
   .rsp_empty(rsp_empty),
   .rsp_pop(rsp_pop),
   .rsp_data(rsp_data)
);

`default_nettype wire

/* bench/tb_partition_header_scorer.sv */
// ----------------------------------------------------------------------------
// Partition header scorer testbench
// Streams partition headers into the scorer and checks every score item
// against a cycle-free software copy of the header parser. A short table of
// directed items comes first, then random headers, mostly well formed, across
// several disk sizes, with random idle bursts on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_partition_header_scorer;
   import phs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS = 120;
   localparam int PHASE_HEADERS = 2;
   localparam int SHAPE_ANY = 0;
   localparam int SHAPE_FULL = 1;
   localparam int SHAPE_LONG = 2;

   typedef struct {
      req_type item;
      bit typed;
      rsp_type want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic req_push;
   logic req_full;
   req_type req_data;
   logic rsp_empty;
   logic rsp_pop;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [WORD_W-1:0] csr_data;

   // Software copy of the block state.
   logic [WORD_W-1:0] disk_size;
   logic [POS_W-1:0] hdr_pos;
   logic [WORD_W-1:0] run_sum;
   logic [WORD_W-1:0] chk_word;
   logic magic_ok;
   logic [WORD_W-1:0] cap_sector;
   logic [PRIOR_W-1:0] cap_prior;
   logic [WORD_W-1:0] cap_next;
   logic [WORD_W-1:0] cap_prev;
   logic [WORD_W-1:0] cap_start;
   logic [WORD_W-1:0] cap_length;
   logic [KIND_W-1:0] cap_kind;
   logic [WORD_W-1:0] cap_subs;
   logic [WORD_W-1:0] cap_main;
   logic [NAME_W-1:0] id_state;

   rsp_type pending_scores[$];
   stim_row_type directed_rows[$];
   logic [KIND_W-1:0] listed_kinds [0:7];
   logic [7:0] bad_bytes [0:4];
   logic [WORD_W-1:0] phase_disk [0:6];

   bit idle_on;
   int errors;
   int items_sent;
   int cycle_count;

   partition_header_scorer u_top (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic kind_listed(input logic [KIND_W-1:0] kind);
      case (kind)
         KIND_EMPTY, KIND_ONE, KIND_SWAP, KIND_NATIVE,
         KIND_88, KIND_FS, KIND_FS_ALT, KIND_SPECIAL: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [NAME_W-1:0] id_scan(input logic [NAME_W-1:0] flags,
                                                 input logic [7:0] ch);
      logic [NAME_W-1:0] next_flags;
      next_flags = flags;
      if (!flags[NAME_ENDED] && !flags[NAME_BAD]) begin
         if (ch == 8'h00) begin
            next_flags[NAME_ENDED] = 1'b1;
         end else if (ch < PRINT_LOW || ch > PRINT_HIGH) begin
            next_flags[NAME_BAD] = 1'b1;
         end else begin
            next_flags[NAME_SEEN] = 1'b1;
         end
      end
      return next_flags;
   endfunction

   function automatic req_type word_item(input logic [WORD_W-1:0] w, input logic last,
                                         input logic [WORD_W-1:0] sector,
                                         input logic [PRIOR_W-1:0] prior);
      req_type item;
      item.header_word = w;
      item.last_word = last;
      item.sector_addr = sector;
      item.prior_evidence = prior;
      return item;
   endfunction

   function automatic rsp_type typed_result(input logic [SCORE_W-1:0] conf,
                                            input logic [PRIOR_W-1:0] ev,
                                            input logic [WORD_W-1:0] stored,
                                            input logic acc);
      rsp_type res;
      res = '0;
      res.confidence = conf;
      res.evidence_bits = ev;
      res.stored_sum = stored;
      res.accept = acc;
      return res;
   endfunction

   task automatic absorb_header_word(input req_type item, output bit done,
                                     output rsp_type res);
      logic [WORD_W-1:0] w;
      logic [PRIOR_W-1:0] ev;
      logic [WORD_W:0] extent_end;
      logic [SCORE_W-1:0] pts;
      int k;
      w = item.header_word;
      if (hdr_pos == POS_STORED) begin
         run_sum = '0;
         magic_ok = 1'b0;
         cap_next = '0;
         cap_prev = '0;
         cap_start = '0;
         cap_length = '0;
         cap_kind = '0;
         cap_subs = '0;
         cap_main = '0;
         id_state = '0;
         cap_sector = item.sector_addr;
         cap_prior = item.prior_evidence;
         chk_word = w;
      end else if (hdr_pos < 9'd256) begin
         run_sum = run_sum + w;
         case (hdr_pos)
            POS_MAGIC: magic_ok = (w == MAGIC_WORD);
            POS_NEXT: cap_next = w;
            POS_PREV: cap_prev = w;
            POS_START: cap_start = w;
            POS_LENGTH: cap_length = w;
            POS_KIND: cap_kind = w[KIND_W-1:0];
            POS_SUBS: cap_subs = w;
            POS_MAIN: cap_main = w;
            default: ;
         endcase
         if (hdr_pos >= POS_NAME_FIRST && hdr_pos <= POS_NAME_LAST) begin
            for (k = 0; k < 4; k++) id_state = id_scan(id_state, w[8*k +: 8]);
         end
      end
      if (hdr_pos < 9'd256) hdr_pos = hdr_pos + 9'd1;

      done = item.last_word;
      res = '0;
      if (!done) return;

      ev = cap_prior;
      pts = '0;
      if (magic_ok) begin
         ev[EV_MAGIC] = 1'b1;
         pts += PTS_MAGIC;
      end
      if (cap_start == cap_sector) begin
         ev[EV_SELF] = 1'b1;
         pts += PTS_SELF;
      end
      if (!cap_prior[EV_REFERENCED] && !ev[EV_MAGIC] && !ev[EV_SELF]) begin
         pts = '0;
      end else begin
         res.computed_sum = run_sum;
         extent_end = {1'b0, cap_start} + {1'b0, cap_length};
         if (chk_word == run_sum) begin
            ev[EV_SUM] = 1'b1;
            pts += PTS_SUM;
         end
         if (cap_length != '0 && cap_start < disk_size && extent_end <= {1'b0, disk_size}) begin
            ev[EV_EXTENT] = 1'b1;
            pts += PTS_EXTENT;
         end
         if (cap_subs <= MAX_SUBS) begin
            ev[EV_SUBS] = 1'b1;
            pts += PTS_SUBS;
         end
         if (kind_listed(cap_kind)) begin
            ev[EV_TYPE] = 1'b1;
            pts += PTS_TYPE;
         end
         if (id_state[NAME_SEEN] && !id_state[NAME_BAD]) begin
            ev[EV_ID] = 1'b1;
            pts += PTS_ID;
         end
         if (!ev[EV_MAGIC] && !ev[EV_EXTENT] && !ev[EV_ID]) pts = '0;
         if (pts > SCORE_MAX) pts = SCORE_MAX;
      end

      res.confidence = pts;
      res.evidence_bits = ev;
      res.stored_sum = chk_word;
      res.accept = (pts >= ACCEPT_MIN) || (cap_sector == '0 && pts >= ACCEPT_MIN_ZERO);
      res.next_link = cap_next;
      res.prev_link = cap_prev;
      res.start_sector = cap_start;
      res.length_sectors = cap_length;
      res.main_link = cap_main;
      res.sub_count = cap_subs;
      res.part_type = cap_kind;
      hdr_pos = '0;
   endtask

   task automatic send_item(input req_type item, input bit typed, input rsp_type want);
      bit done;
      rsp_type res;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      items_sent++;
      absorb_header_word(item, done, res);
      if (done) pending_scores.insert(pending_scores.size(), typed ? want : res);
   endtask

   task automatic add_row(input req_type item, input bit typed, input rsp_type want);
      stim_row_type row;
      row.item = item;
      row.typed = typed;
      row.want = want;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_disk_size(input logic [WORD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      disk_size = value;
   endtask

   task automatic send_random_header(input int shape);
      logic [WORD_W-1:0] hw [0:299];
      logic [7:0] id_bytes [0:31];
      logic [WORD_W-1:0] sector;
      logic [WORD_W-1:0] room;
      logic [WORD_W-1:0] total;
      logic [PRIOR_W-1:0] prior;
      bit shaped;
      int n;
      int r;
      int k;
      int stop;
      r = $urandom_range(0, 99);
      if (shape == SHAPE_FULL || (shape == SHAPE_ANY && r < 3)) begin
         n = 256;
      end else if (shape == SHAPE_LONG || (shape == SHAPE_ANY && r < 6)) begin
         n = $urandom_range(257, 300);
      end else if (r < 14) begin
         n = $urandom_range(1, 16);
      end else begin
         n = $urandom_range(17, 40);
      end
      shaped = ($urandom_range(0, 9) < 8);
      for (k = 0; k < 300; k++) hw[k] = $urandom;

      r = $urandom_range(0, 15);
      if (r == 0) begin
         sector = '0;
      end else if (r == 1) begin
         sector = '1;
      end else if (shaped && disk_size != 0) begin
         sector = $urandom_range(0, disk_size - 1);
      end else begin
         sector = $urandom;
      end
      prior = PRIOR_W'($urandom_range(0, 511));
      r = $urandom_range(0, 7);
      if (r == 0) begin
         prior = '0;
      end else if (r < 5) begin
         prior[EV_REFERENCED] = 1'b0;
      end

      if (shaped) begin
         if ($urandom_range(0, 7) != 0) hw[POS_MAGIC] = MAGIC_WORD;
         if ($urandom_range(0, 7) != 0) hw[POS_START] = sector;
         if (disk_size > hw[POS_START]) begin
            room = disk_size - hw[POS_START];
            r = $urandom_range(0, 7);
            if (r == 0) begin
               hw[POS_LENGTH] = room;
            end else if (r == 1) begin
               hw[POS_LENGTH] = room + 1;
            end else if (r == 2) begin
               hw[POS_LENGTH] = '0;
            end else begin
               hw[POS_LENGTH] = $urandom_range(1, room);
            end
         end
         if ($urandom_range(0, 7) != 0) hw[POS_KIND][KIND_W-1:0] = listed_kinds[$urandom_range(0, 7)];
         r = $urandom_range(0, 7);
         if (r == 0) begin
            hw[POS_SUBS] = MAX_SUBS + 1;
         end else if (r == 1) begin
            hw[POS_SUBS] = MAX_SUBS;
         end else if (r < 7) begin
            hw[POS_SUBS] = $urandom_range(0, MAX_SUBS);
         end

         for (k = 0; k < 32; k++) id_bytes[k] = 8'($urandom_range(PRINT_LOW, PRINT_HIGH));
         stop = $urandom_range(0, 31);
         case ($urandom_range(0, 5))
            1, 2: id_bytes[stop] = 8'h00;
            3: id_bytes[0] = 8'h00;
            4: id_bytes[stop] = bad_bytes[$urandom_range(0, 4)];
            5: begin
               id_bytes[stop] = 8'h00;
               if (stop < 31) id_bytes[stop+1] = bad_bytes[$urandom_range(0, 4)];
            end
            default: ;
         endcase
         for (k = 0; k < 8; k++) begin
            hw[POS_NAME_FIRST+k] = {id_bytes[4*k+3], id_bytes[4*k+2],
                                    id_bytes[4*k+1], id_bytes[4*k]};
         end
      end

      total = '0;
      for (k = 1; k < n && k < 256; k++) total = total + hw[k];
      r = $urandom_range(0, 9);
      if (shaped && r < 8) begin
         hw[POS_STORED] = total;
      end else if (r == 8) begin
         hw[POS_STORED] = total + 1;
      end

      // Sector and prior only matter on word 0; later words carry noise there.
      for (k = 0; k < n; k++) begin
         if (k == 0) begin
            send_item(word_item(hw[k], n == 1, sector, prior), 1'b0, '0);
         end else begin
            send_item(word_item(hw[k], k == n - 1, $urandom,
                                PRIOR_W'($urandom_range(0, 511))),
                      1'b0, '0);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_scores.size() == 0) begin
         $display("%0t: unexpected score item, expected none actual %h", $time, got);
         errors++;
      end else begin
         want = pending_scores.pop_front();
         check_field("confidence", WORD_W'(want.confidence), WORD_W'(got.confidence));
         check_field("evidence_bits", WORD_W'(want.evidence_bits),
                     WORD_W'(got.evidence_bits));
         check_field("computed_sum", want.computed_sum, got.computed_sum);
         check_field("stored_sum", want.stored_sum, got.stored_sum);
         check_field("accept", WORD_W'(want.accept), WORD_W'(got.accept));
         check_field("next_link", want.next_link, got.next_link);
         check_field("prev_link", want.prev_link, got.prev_link);
         check_field("start_sector", want.start_sector, got.start_sector);
         check_field("length_sectors", want.length_sectors, got.length_sectors);
         check_field("main_link", want.main_link, got.main_link);
         check_field("sub_count", want.sub_count, got.sub_count);
         check_field("part_type", WORD_W'(want.part_type), WORD_W'(got.part_type));
      end
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) check_result(rsp_data);
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      logic [WORD_W-1:0] hdr [0:16];
      int k;
      int ph;
      int phase_start;
      int phase_headers;
      int shape;

      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      idle_on = 1'b1;
      errors = 0;
      items_sent = 0;
      disk_size = '0;
      hdr_pos = '0;
      run_sum = '0;
      chk_word = '0;
      magic_ok = 1'b0;
      cap_sector = '0;
      cap_prior = '0;
      cap_next = '0;
      cap_prev = '0;
      cap_start = '0;
      cap_length = '0;
      cap_kind = '0;
      cap_subs = '0;
      cap_main = '0;
      id_state = '0;
      listed_kinds = '{KIND_EMPTY, KIND_ONE, KIND_SWAP, KIND_NATIVE,
                       KIND_88, KIND_FS, KIND_FS_ALT, KIND_SPECIAL};
      bad_bytes = '{8'h01, 8'h1f, 8'h7f, 8'h80, 8'hff};
      phase_disk = '{32'hffff_ffff, 32'd1, $urandom, 32'h0001_0000, 32'd0,
                     $urandom, 32'hffff_ffff};

      // One-word headers whose scores follow directly from the empty capture.
      add_row(word_item(32'h0, 1'b1, 32'h0, 9'h000), 1'b1,
              typed_result(7'd0, 9'h036, 32'h0, 1'b0));
      add_row(word_item(32'hffff_ffff, 1'b1, 32'hffff_ffff, 9'h000), 1'b1,
              typed_result(7'd0, 9'h000, 32'hffff_ffff, 1'b0));
      add_row(word_item(32'h1234_5678, 1'b1, 32'd5, 9'h1ff), 1'b1,
              typed_result(7'd10, 9'h1ff, 32'h1234_5678, 1'b0));
      add_row(word_item(32'h0, 1'b1, 32'd7, 9'h080), 1'b1,
              typed_result(7'd0, 9'h0b4, 32'h0, 1'b0));
      add_row(word_item(32'h1, 1'b1, 32'h0, 9'h001), 1'b1,
              typed_result(7'd30, 9'h033, 32'h1, 1'b1));

      // A short, well-formed header with a terminated printable ID.
      hdr[POS_MAGIC] = MAGIC_WORD;
      hdr[POS_NEXT] = 32'h0000_0100;
      hdr[POS_PREV] = 32'h0000_0200;
      hdr[POS_NAME_FIRST] = 32'h4443_4241;
      hdr[POS_NAME_FIRST+1] = 32'hff00_0045;
      for (k = 6; k < 16; k++) hdr[k] = 32'h0101_0101;
      hdr[POS_START] = 32'd16;
      hdr[POS_STORED] = '0;
      for (k = 1; k < 17; k++) hdr[POS_STORED] = hdr[POS_STORED] + hdr[k];
      for (k = 0; k < 17; k++) add_row(word_item(hdr[k], k == 16, 32'd16, 9'h000), 1'b0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      set_disk_size(32'd0);
      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end

      for (ph = 0; ph < 7; ph++) begin
         drain_results();
         set_disk_size(phase_disk[ph]);
         idle_on = (ph != 6);
         if (ph == 0 || ph == 3) begin
            shape = SHAPE_FULL;
         end else if (ph == 1 || ph == 4) begin
            shape = SHAPE_LONG;
         end else begin
            shape = SHAPE_ANY;
         end
         phase_start = items_sent;
         send_random_header(shape);
         phase_headers = 1;
         while (items_sent - phase_start < PHASE_ITEMS || phase_headers < PHASE_HEADERS) begin
            send_random_header(SHAPE_ANY);
            phase_headers++;
         end
      end
      drain_results();

      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/phs_pkg.sv
rtl/phs_front.sv
rtl/phs_queue.sv
rtl/phs_back.sv
rtl/partition_header_scorer.sv
rtl/phs_checker.sv
bench/tb_partition_header_scorer.sv
